FILE: sv/glzw_pkg.sv
package glzw_pkg;

    localparam int DATA_BITS   = 8;
    localparam int SYMBOLS     = 256;
    localparam int CODE_W      = 12;
    localparam int CWIDTH_W    = 4;
    localparam int CLEAR_CODE  = 256;
    localparam int FIRST_FREE  = 258;
    localparam int START_WIDTH = 9;
    // Wide enough to compare a free-code count against the mask of a 12-bit code.
    localparam int CMP_W       = CODE_W + 1;

    typedef struct packed {
        logic [CODE_W-1:0]   code;
        logic [CWIDTH_W-1:0] code_width;
        logic                final_code;
    } t_result;

endpackage

FILE: sv/glzw_pix_if.sv
interface glzw_pix_if import glzw_pkg::*; ();

    logic                 valid;
    logic                 ready;
    logic [DATA_BITS-1:0] pixel_index;
    logic                 first_pixel;
    logic                 last_pixel;

    modport source (output valid, output pixel_index, output first_pixel, output last_pixel,
                    input ready);
    modport sink   (input valid, input pixel_index, input first_pixel, input last_pixel,
                    output ready);

endinterface

FILE: sv/glzw_code_if.sv
interface glzw_code_if import glzw_pkg::*; ();

    logic                valid;
    logic                ready;
    logic [CODE_W-1:0]   code;
    logic [CWIDTH_W-1:0] code_width;
    logic                final_code;

    modport source (output valid, output code, output code_width, output final_code,
                    input ready);
    modport sink   (input valid, input code, input code_width, input final_code,
                    output ready);

endinterface

FILE: sv/gif_lzw_encoder_core.sv
// A first pixel is handled in the idle state alone. Any other pixel goes on to a lookup of
// the dictionary and, when a stored entry is a candidate, to a confirmation read of the
// code-to-address table; a miss or a confirmed hit ends the pixel and returns to idle.
// A new pixel is started only from idle and only while the output FIFO holds at most one code.
// Reset (synchronous, active low) clears the control state; the dictionary is never swept,
// an entry counts only if its code is below the next free code and maps back to it.
module gif_lzw_encoder_core import glzw_pkg::*; #(
    parameter int DICT_CODES = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    glzw_pix_if.sink    i_pix,
    glzw_code_if.source o_code
);

    localparam int CB    = $clog2(DICT_CODES);
    localparam int AW    = CB + DATA_BITS;
    localparam int CNT_W = CB + 1;

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_LOOK  = 3'b010,
        S_CHECK = 3'b100
    } t_state;

    t_state               r_state, n_state;
    logic                 r_in_valid;
    logic [DATA_BITS-1:0] r_in_pixel;
    logic                 r_in_first;
    logic                 r_in_last;
    logic [DATA_BITS-1:0] r_pixel;
    logic                 r_last;
    logic [AW-1:0]        r_idx;
    logic [CB-1:0]        r_entry, n_entry;
    logic [CODE_W-1:0]    r_prefix, n_prefix;
    logic [CNT_W-1:0]     r_nfc, n_nfc;
    logic [CWIDTH_W-1:0]  r_width, n_width;

    logic                 start;
    logic [2:0]           fifo_level;
    logic [1:0]           push_cnt;
    t_result              push_items [3];

    logic [CB-1:0]        dict_rdata;
    logic [AW-1:0]        c2a_rdata;
    logic                 dict_re;
    logic                 dict_we;
    logic                 c2a_re;
    logic [AW-1:0]        look_addr;

    logic                 cand;
    logic                 do_miss;
    logic                 room;
    logic [CNT_W-1:0]     nfc_a;
    logic [CWIDTH_W-1:0]  width_a;
    logic [CWIDTH_W-1:0]  width_b;
    logic [CMP_W-1:0]     mask_a;
    logic                 grow;
    t_result              res_prefix;
    t_result              res_clear;
    t_result              res_final;

    // Start needs room for the largest burst of three codes.
    assign start       = (r_state == S_IDLE) && r_in_valid && (fifo_level <= 3'd1);
    assign i_pix.ready = !r_in_valid || start;
    assign look_addr   = {r_prefix[CB-1:0], r_in_pixel};
    assign dict_re     = start && !r_in_first;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_pix.valid && i_pix.ready) begin
            r_in_valid <= 1'b1;
        end else if (start) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_pix.valid && i_pix.ready) begin
            r_in_pixel <= i_pix.pixel_index;
            r_in_first <= i_pix.first_pixel;
            r_in_last  <= i_pix.last_pixel;
        end
        if (start) begin
            r_pixel <= r_in_pixel;
            r_last  <= r_in_last;
            r_idx   <= look_addr;
        end
        r_entry <= n_entry;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_prefix <= '0;
            r_nfc    <= CNT_W'(FIRST_FREE);
            r_width  <= CWIDTH_W'(START_WIDTH);
        end else begin
            r_state  <= n_state;
            r_prefix <= n_prefix;
            r_nfc    <= n_nfc;
            r_width  <= n_width;
        end
    end

    // A stored code is a candidate only if it was handed out since the last clear.
    assign cand = (dict_rdata >= CB'(FIRST_FREE)) && ({1'b0, dict_rdata} < r_nfc);

    // Miss handling: assign the free code or start the dictionary over.
    assign room    = (r_nfc < CNT_W'(DICT_CODES));
    assign nfc_a   = room ? r_nfc + CNT_W'(1) : CNT_W'(FIRST_FREE);
    assign width_a = room ? r_width : CWIDTH_W'(START_WIDTH);
    assign mask_a  = (CMP_W'(1) << width_a) - CMP_W'(1);
    assign grow    = ((CMP_W'(nfc_a) - CMP_W'(1)) > mask_a) && (nfc_a < CNT_W'(DICT_CODES));
    assign width_b = grow ? width_a + CWIDTH_W'(1) : width_a;

    always_comb begin
        res_prefix = '{code: r_prefix, code_width: r_width, final_code: 1'b0};
        res_clear  = '{code: CODE_W'(CLEAR_CODE), code_width: r_width, final_code: 1'b0};
        res_final  = '{code: CODE_W'(r_pixel), code_width: width_b, final_code: 1'b1};

        n_state  = r_state;
        n_prefix = r_prefix;
        n_nfc    = r_nfc;
        n_width  = r_width;
        n_entry  = r_entry;
        c2a_re   = 1'b0;
        dict_we  = 1'b0;
        do_miss  = 1'b0;
        push_cnt = 2'd0;
        for (int k = 0; k < 3; k++) begin
            push_items[k] = '0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    if (r_in_first) begin
                        push_items[0] = '{code: CODE_W'(CLEAR_CODE),
                                          code_width: CWIDTH_W'(START_WIDTH),
                                          final_code: 1'b0};
                        push_items[1] = '{code: CODE_W'(r_in_pixel),
                                          code_width: CWIDTH_W'(START_WIDTH),
                                          final_code: 1'b1};
                        push_cnt = r_in_last ? 2'd2 : 2'd1;
                        n_prefix = CODE_W'(r_in_pixel);
                        n_nfc    = CNT_W'(FIRST_FREE);
                        n_width  = CWIDTH_W'(START_WIDTH);
                    end else begin
                        n_state = S_LOOK;
                    end
                end
            end
            S_LOOK: begin
                if (cand) begin
                    n_entry = dict_rdata;
                    c2a_re  = 1'b1;
                    n_state = S_CHECK;
                end else begin
                    do_miss = 1'b1;
                end
            end
            S_CHECK: begin
                if (c2a_rdata == r_idx) begin
                    n_prefix      = CODE_W'(r_entry);
                    push_items[0] = '{code: CODE_W'(r_entry), code_width: r_width,
                                      final_code: 1'b1};
                    push_cnt      = r_last ? 2'd1 : 2'd0;
                    n_state       = S_IDLE;
                end else begin
                    do_miss = 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (do_miss) begin
            dict_we       = room;
            n_nfc         = nfc_a;
            n_width       = width_b;
            n_prefix      = CODE_W'(r_pixel);
            n_state       = S_IDLE;
            push_items[0] = res_prefix;
            push_items[1] = room ? res_final : res_clear;
            push_items[2] = res_final;
            push_cnt      = 2'd1 + 2'(!room) + 2'(r_last);
        end
    end

    glzw_ram #(
        .WIDTH (CB),
        .DEPTH (DICT_CODES * SYMBOLS)
    ) u_dict (
        .i_clk   (i_clk),
        .i_we    (dict_we),
        .i_waddr (r_idx),
        .i_wdata (r_nfc[CB-1:0]),
        .i_re    (dict_re),
        .i_raddr (look_addr),
        .o_rdata (dict_rdata)
    );

    // Reverse table: which dictionary address each handed-out code belongs to.
    glzw_ram #(
        .WIDTH (AW),
        .DEPTH (DICT_CODES)
    ) u_c2a (
        .i_clk   (i_clk),
        .i_we    (dict_we),
        .i_waddr (r_nfc[CB-1:0]),
        .i_wdata (r_idx),
        .i_re    (c2a_re),
        .i_raddr (dict_rdata),
        .o_rdata (c2a_rdata)
    );

    glzw_out_fifo u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cnt   (push_cnt),
        .i_items (push_items),
        .o_level (fifo_level),
        .o_code  (o_code)
    );

endmodule

FILE: sv/glzw_ram.sv
module glzw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    bit   [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // A read of the address being written returns the old contents.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: sv/glzw_out_fifo.sv
module glzw_out_fifo import glzw_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [1:0]  i_cnt,
    input  t_result     i_items [3],
    output logic [2:0]  o_level,
    glzw_code_if.source o_code
);

    t_result    r_mem [4];
    logic [1:0] r_wptr;
    logic [1:0] r_rptr;
    logic [2:0] r_level;
    logic [2:0] n_level;
    logic       pop;

    assign pop     = o_code.valid && o_code.ready;
    assign n_level = r_level + 3'(i_cnt) - 3'(pop);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_level <= '0;
        end else begin
            r_wptr  <= r_wptr + i_cnt;
            r_rptr  <= r_rptr + 2'(pop);
            r_level <= n_level;
        end
    end

    // Up to three items go in per cycle, packed from slot zero.
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 3; k++) begin
            if (2'(k) < i_cnt) begin
                r_mem[r_wptr + 2'(k)] <= i_items[k];
            end
        end
    end

    assign o_code.valid      = (r_level != 3'd0);
    assign o_code.code       = r_mem[r_rptr].code;
    assign o_code.code_width = r_mem[r_rptr].code_width;
    assign o_code.final_code = r_mem[r_rptr].final_code;
    assign o_level           = r_level;

endmodule
